FILE: hdl/ape_pkg.sv
// Package for the add/subtract expression evaluator.
// Holds the character codes, the classified operation type and the status codes.
// Depends on nothing.
package ape_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam int         VALUE_W    = 32;

   typedef enum logic [2:0] {
      OP_DIGIT = 3'd0,
      OP_PLUS  = 3'd1,
      OP_MINUS = 3'd2,
      OP_OPEN  = 3'd3,
      OP_CLOSE = 3'd4,
      OP_OTHER = 3'd5
   } op_kind_type;

   typedef enum logic [1:0] {
      ST_OK              = 2'd0,
      ST_UNMATCHED_CLOSE = 2'd1,
      ST_OVERFLOW        = 2'd2,
      ST_UNCLOSED        = 2'd3
   } status_type;

   typedef struct packed {
      op_kind_type kind;
      logic [3:0]  digit;
      logic        last;
   } op_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } result_type;

endpackage

FILE: hdl/ape_front.sv
// Front end of the evaluator: classifies each character and queues the operation.
// Uses ape_pkg; feeds ape_back through a two-entry queue.
module ape_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  logic [7:0]      req_ch,
   input  logic            req_last,
   output logic            op_valid,
   input  logic            op_take,
   output ape_pkg::op_type op_data
);

   ape_pkg::op_type op_q_ff [2];
   ape_pkg::op_type op_new;
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            wr_en, rd_en;
   logic [7:0]      digit_off;

   assign digit_off = req_ch - ape_pkg::CHAR_ZERO;

   always_comb begin
      op_new.last  = req_last;
      op_new.digit = digit_off[3:0];
      priority if (req_ch >= ape_pkg::CHAR_ZERO && req_ch <= ape_pkg::CHAR_NINE) begin
         op_new.kind = ape_pkg::OP_DIGIT;
      end else if (req_ch == ape_pkg::CHAR_PLUS) begin
         op_new.kind = ape_pkg::OP_PLUS;
      end else if (req_ch == ape_pkg::CHAR_MINUS) begin
         op_new.kind = ape_pkg::OP_MINUS;
      end else if (req_ch == ape_pkg::CHAR_OPEN) begin
         op_new.kind = ape_pkg::OP_OPEN;
      end else if (req_ch == ape_pkg::CHAR_CLOSE) begin
         op_new.kind = ape_pkg::OP_CLOSE;
      end else begin
         op_new.kind = ape_pkg::OP_OTHER;
      end
   end

   assign req_full = (count_ff == 2'd2);
   assign op_valid = (count_ff != 2'd0);
   assign op_data  = op_q_ff[rd_ptr_ff];
   assign wr_en    = req_push && !req_full;
   assign rd_en    = op_valid && op_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         op_q_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

FILE: hdl/ape_back.sv
// Back end of the evaluator: keeps the nesting stack; one operation a cycle, a final one
// only if ape_outq has room. Uses ape_pkg; ape_front feeds it, it feeds ape_outq.
module ape_back #(
   parameter int NEST_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   output logic                op_take,
   input  ape_pkg::op_type     op_data,
   input  logic                res_full,
   output logic                res_push,
   output ape_pkg::result_type res_data
);

   localparam int LVL_W = $clog2(NEST_DEPTH + 1);
   localparam int IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int VW    = ape_pkg::VALUE_W;

   // The top frame lives in a register; the frames below it live in the memory,
   // and the one just under the top is kept read out in rd_ff.
   logic [VW:0]        mem [NEST_DEPTH];
   logic [VW:0]        top_ff, top_in;
   logic [VW:0]        rd_ff;
   logic [VW-1:0]      total_ff, total_in;
   logic [VW-1:0]      pend_ff, pend_in;
   logic               sign_ff, sign_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   ape_pkg::status_type err_ff, err_in;
   logic [VW-1:0]      total_c, pend_x10, pend_dig, close_sum;
   logic               fire, do_push;
   logic [LVL_W-1:0]   rd_addr, wr_addr;

   assign op_take = !(op_data.last && res_full);
   assign fire    = op_valid && op_take;

   assign total_c  = sign_ff ? (total_ff - pend_ff) : (total_ff + pend_ff);
   assign pend_x10 = {pend_ff[VW-4:0], 3'b000} + {pend_ff[VW-2:0], 1'b0};
   assign pend_dig = pend_x10 + {{(VW-4){1'b0}}, op_data.digit};
   assign close_sum = top_ff[0] ? (top_ff[VW:1] - total_c) : (top_ff[VW:1] + total_c);

   always_comb begin
      logic [VW-1:0]       tot_n;
      logic [VW-1:0]       pend_n;
      logic                sign_n;
      logic [LVL_W-1:0]    lvl_n;
      ape_pkg::status_type err_n;
      tot_n   = total_ff;
      pend_n  = pend_ff;
      sign_n  = sign_ff;
      lvl_n   = lvl_ff;
      err_n   = err_ff;
      do_push = 1'b0;
      top_in  = top_ff;
      unique case (op_data.kind)
         ape_pkg::OP_DIGIT: begin
            pend_n = pend_dig;
         end
         ape_pkg::OP_PLUS: begin
            tot_n  = total_c;
            pend_n = '0;
            sign_n = 1'b0;
         end
         ape_pkg::OP_MINUS: begin
            tot_n  = total_c;
            pend_n = '0;
            sign_n = 1'b1;
         end
         ape_pkg::OP_OPEN: begin
            pend_n = '0;
            if (lvl_ff < LVL_W'(NEST_DEPTH)) begin
               do_push = 1'b1;
               top_in  = {total_c, sign_ff};
               tot_n   = '0;
               sign_n  = 1'b0;
               lvl_n   = lvl_ff + LVL_W'(1);
            end else begin
               tot_n = total_c;
               if (err_ff == ape_pkg::ST_OK) err_n = ape_pkg::ST_OVERFLOW;
            end
         end
         ape_pkg::OP_CLOSE: begin
            pend_n = '0;
            if (lvl_ff != '0) begin
               top_in = rd_ff;
               tot_n  = close_sum;
               lvl_n  = lvl_ff - LVL_W'(1);
            end else begin
               tot_n = total_c;
               if (err_ff == ape_pkg::ST_OK) err_n = ape_pkg::ST_UNMATCHED_CLOSE;
            end
         end
         default: begin
            tot_n  = total_c;
            pend_n = '0;
         end
      endcase
      // On the final character the pending number is committed before the result goes out.
      if (op_data.last) begin
         tot_n  = sign_n ? (tot_n - pend_n) : (tot_n + pend_n);
         if (lvl_n != '0 && err_n == ape_pkg::ST_OK) err_n = ape_pkg::ST_UNCLOSED;
      end
      res_data.value  = tot_n;
      res_data.status = err_n;
      if (op_data.last) begin
         total_in = '0;
         pend_in  = '0;
         sign_in  = 1'b0;
         lvl_in   = '0;
         err_in   = ape_pkg::ST_OK;
      end else begin
         total_in = tot_n;
         pend_in  = pend_n;
         sign_in  = sign_n;
         lvl_in   = lvl_n;
         err_in   = err_n;
      end
   end

   assign res_push = fire && op_data.last;
   assign wr_addr  = lvl_ff - LVL_W'(1);
   assign rd_addr  = (fire ? lvl_in : lvl_ff) - LVL_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         pend_ff  <= '0;
         sign_ff  <= 1'b0;
         lvl_ff   <= '0;
         err_ff   <= ape_pkg::ST_OK;
      end else if (fire) begin
         total_ff <= total_in;
         pend_ff  <= pend_in;
         sign_ff  <= sign_in;
         lvl_ff   <= lvl_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         top_ff <= top_in;
      end
      if (fire && do_push && lvl_ff != '0) begin
         mem[wr_addr[IDX_W-1:0]] <= top_ff;
      end
      // A push moves the old top just under the new one, so it is forwarded.
      if (fire && do_push) begin
         rd_ff <= top_ff;
      end else begin
         rd_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

endmodule

FILE: hdl/ape_outq.sv
// Result queue of the evaluator: two entries between the back end and the result ports.
// Uses ape_pkg.
module ape_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_push,
   output logic                res_full,
   input  ape_pkg::result_type res_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output ape_pkg::result_type rsp_data
);

   ape_pkg::result_type q_ff [2];
   logic                wr_ptr_ff, rd_ptr_ff;
   logic [1:0]          count_ff, count_in;
   logic                wr_en, rd_en;

   assign res_full  = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign wr_en     = res_push && !res_full;
   assign rd_en     = rsp_pop && !rsp_empty;
   assign count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ wr_en;
         rd_ptr_ff <= rd_ptr_ff ^ rd_en;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule

FILE: hdl/add_sub_paren_expression_evaluator.sv
// Add/subtract expression evaluator with nested parentheses.
// Characters enter one item at a time on the req_ queue port: an item is taken
// at a clock edge with req_push high and req_full low. req_last marks the final
// character of an expression; only that item produces a result.
// Results leave on the rsp_ queue port: rsp_value and rsp_status are valid while
// rsp_empty is low and are taken at an edge with rsp_pop high.
// Throughput is one character per cycle unless a final character meets a full
// result queue; the back end handles each operation, stack pushes and pops too,
// against a top-of-stack register and a memory with a prefetched next entry.
// A result reaches the ports once its last character has passed the front queue
// and the back end into the result queue.
// A two-entry queue sits between front and back and another after the back end;
// when the receiver stalls, results wait there, then the back end stops on the
// next final character and req_full rises once the front queue fills.
// Synchronous reset empties both queues and clears the evaluation state; the
// nesting stack memory is not cleared, as only written entries are ever read.
// Status: 0 ok, 1 unmatched close, 2 nesting overflow, 3 unclosed open; the
// first error of an expression is kept.
// Depends on ape_pkg, ape_front, ape_back and ape_outq.
module add_sub_paren_expression_evaluator #(
   parameter int NEST_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_ch,
   input  logic               req_last,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_status
);

   ape_pkg::op_type     op_data;
   logic                op_valid, op_take;
   logic                res_push, res_full;
   ape_pkg::result_type res_data, rsp_data;

   ape_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_ch   (req_ch),
      .req_last (req_last),
      .op_valid (op_valid),
      .op_take  (op_take),
      .op_data  (op_data)
   );

   ape_back #(.NEST_DEPTH(NEST_DEPTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_take  (op_take),
      .op_data  (op_data),
      .res_full (res_full),
      .res_push (res_push),
      .res_data (res_data)
   );

   ape_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .res_push  (res_push),
      .res_full  (res_full),
      .res_data  (res_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_value  = $signed(rsp_data.value);
   assign rsp_status = rsp_data.status;

endmodule

FILE: hdl/ape_checker.sv
// Port-level checks for the expression evaluator, bound to the top level.
// Depends on add_sub_paren_expression_evaluator.
module ape_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [31:0] rsp_value,
   input logic [1:0]         rsp_status
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input queue full after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result withdrawn");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_value) && $stable(rsp_status)))
      else $error("waiting result changed");

endmodule

bind add_sub_paren_expression_evaluator ape_checker u_ape_checker (
   .clock      (clock),
   .reset      (reset),
   .req_full   (req_full),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);

FILE: tb/evaluator_checker.sv
// Checker for the add/subtract expression evaluator: watches both queue ports,
// predicts the result of each expression from the accepted characters and
// compares every result field by field. Depends on ape_pkg.
module evaluator_checker #(
   parameter int NEST_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [7:0]         req_ch,
   input  logic               req_last,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic signed [31:0] rsp_value,
   input  logic [1:0]         rsp_status,
   output int                 mismatch_count,
   output int                 results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // Evaluation state of the expression being received.
   logic [31:0]         total;
   logic [31:0]         pending;
   logic                negative;
   logic [31:0]         saved_total [NEST_DEPTH];
   logic                saved_negative [NEST_DEPTH];
   int                  level;
   ape_pkg::status_type first_error;

   ape_pkg::result_type awaited_results [$];

   function automatic void clear_expression();
      total       = '0;
      pending     = '0;
      negative    = 1'b0;
      level       = 0;
      first_error = ape_pkg::ST_OK;
   endfunction

   function automatic void commit_pending();
      total   = negative ? total - pending : total + pending;
      pending = '0;
   endfunction

   // Only the first error of an expression is reported.
   function automatic void note_error(input ape_pkg::status_type code);
      if (first_error == ape_pkg::ST_OK) begin
         first_error = code;
      end
   endfunction

   function automatic void evaluate_char(input logic [7:0] c, input logic fin);
      ape_pkg::result_type outcome;
      if (c >= ape_pkg::CHAR_ZERO && c <= ape_pkg::CHAR_NINE) begin
         pending = pending * 32'd10 + 32'(c - ape_pkg::CHAR_ZERO);
      end else begin
         commit_pending();
         unique case (c)
            ape_pkg::CHAR_PLUS: begin
               negative = 1'b0;
            end
            ape_pkg::CHAR_MINUS: begin
               negative = 1'b1;
            end
            ape_pkg::CHAR_OPEN: begin
               if (level < NEST_DEPTH) begin
                  saved_total[level]    = total;
                  saved_negative[level] = negative;
                  level++;
                  total    = '0;
                  negative = 1'b0;
               end else begin
                  note_error(ape_pkg::ST_OVERFLOW);
               end
            end
            ape_pkg::CHAR_CLOSE: begin
               // The sign inside the parentheses is deliberately kept.
               if (level > 0) begin
                  level--;
                  total = saved_negative[level] ? saved_total[level] - total
                                                : saved_total[level] + total;
               end else begin
                  note_error(ape_pkg::ST_UNMATCHED_CLOSE);
               end
            end
            default: begin
            end
         endcase
      end
      if (fin) begin
         commit_pending();
         if (level != 0) begin
            note_error(ape_pkg::ST_UNCLOSED);
         end
         outcome.value  = total;
         outcome.status = first_error;
         awaited_results.insert(awaited_results.size(), outcome);
         clear_expression();
      end
   endfunction

   always @(posedge clock) begin
      ape_pkg::result_type want;
      if (reset) begin
         clear_expression();
         awaited_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: value %0d status %0d", rsp_value, rsp_status);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", $signed(want.value), rsp_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (req_push && !req_full) begin
            evaluate_char(req_ch, req_last);
         end
      end
      results_outstanding = awaited_results.size();
   end

endmodule

FILE: tb/testbench.sv
// Top of the testbench for the add/subtract expression evaluator: clock, reset,
// directed and random expressions and the verdict. Checking is done by
// evaluator_checker; depends on ape_pkg and the evaluator RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NEST_DEPTH = 16;
   localparam int ITEM_TARGET = 600;
   localparam int MIN_EXPRESSIONS = 48;
   localparam int SETTLE_CYCLES = 20;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic [7:0]         req_ch;
   logic               req_last;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [31:0] rsp_value;
   logic [1:0]         rsp_status;
   int                 mismatch_count;
   int                 results_outstanding;

   int req_idle_pct;
   int rsp_idle_pct;
   int items_sent;

   add_sub_paren_expression_evaluator #(.NEST_DEPTH(NEST_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

   evaluator_checker #(.NEST_DEPTH(NEST_DEPTH)) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_ch              (req_ch),
      .req_last            (req_last),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_value           (rsp_value),
      .rsp_status          (rsp_status),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   always #2 clock = ~clock;

   // The receiver stalls at random; the rate is set by the stimulus phase.
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Holds an item until a clock edge at which the block takes it.
   task automatic send_char(input logic [7:0] c, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_ch   <= c;
      req_last <= fin;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_char(s[i], i == s.len() - 1);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      wait (results_outstanding == 0);
   endtask

   function automatic void append_char(ref logic [7:0] chars [$], input logic [7:0] c);
      chars.insert(chars.size(), c);
   endfunction

   function automatic void add_number(ref logic [7:0] chars [$]);
      int digits;
      digits = ($urandom_range(9) < 7) ? $urandom_range(1, 3) : $urandom_range(1, 11);
      repeat (digits) append_char(chars, ape_pkg::CHAR_ZERO + 8'($urandom_range(9)));
   endfunction

   function automatic logic [7:0] random_sign();
      return $urandom_range(1) ? ape_pkg::CHAR_MINUS : ape_pkg::CHAR_PLUS;
   endfunction

   // Mostly balanced expressions with random content; some run past the
   // nesting limit, some leave parentheses open, and the rest are noise.
   function automatic void build_expression(ref logic [7:0] chars [$]);
      int mode;
      int depth;
      int max_depth;
      int terms;
      mode      = $urandom_range(99);
      depth     = 0;
      max_depth = 6;
      if (mode >= 82) begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(5))
               0: append_char(chars, ape_pkg::CHAR_OPEN);
               1: append_char(chars, ape_pkg::CHAR_CLOSE);
               2: append_char(chars, random_sign());
               3: append_char(chars, ape_pkg::CHAR_ZERO + 8'($urandom_range(9)));
               default: append_char(chars, 8'($urandom_range(255)));
            endcase
         end
         return;
      end
      if (mode < 10) begin
         max_depth = NEST_DEPTH + 2;
         repeat ($urandom_range(NEST_DEPTH - 4, NEST_DEPTH + 2)) begin
            if ($urandom_range(2) == 0) append_char(chars, random_sign());
            append_char(chars, ape_pkg::CHAR_OPEN);
            depth++;
         end
      end
      terms = $urandom_range(1, 8);
      for (int i = 0; i < terms; i++) begin
         if (i > 0) append_char(chars, random_sign());
         else if ($urandom_range(3) == 0) append_char(chars, random_sign());
         while (depth < max_depth && $urandom_range(3) == 0) begin
            append_char(chars, ape_pkg::CHAR_OPEN);
            depth++;
            if ($urandom_range(2) == 0) append_char(chars, random_sign());
         end
         add_number(chars);
         while (depth > 0 && $urandom_range(2) == 0) begin
            append_char(chars, ape_pkg::CHAR_CLOSE);
            depth--;
         end
         if ($urandom_range(9) == 0) append_char(chars, 8'h20);
      end
      if ($urandom_range(9) != 0) begin
         repeat (depth) append_char(chars, ape_pkg::CHAR_CLOSE);
      end
   endfunction

   initial begin
      logic [7:0] chars [$];
      int         expressions;
      reset        = 1'b1;
      req_push     = 1'b0;
      req_ch       = '0;
      req_last     = 1'b0;
      req_idle_pct = 28;
      rsp_idle_pct = 28;
      items_sent   = 0;
      expressions  = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: stray close, lone open, all operators, both extreme
      // character codes and a number that wraps past 32 bits.
      send_text(")");
      send_text("(");
      send_text("-(1+9)");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      send_text("9999999999");
      drain_results();

      while (items_sent < ITEM_TARGET || expressions < MIN_EXPRESSIONS) begin
         if (expressions >= 8 && expressions < 20) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 28;
            rsp_idle_pct = 28;
         end
         chars.delete();
         build_expression(chars);
         foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
         expressions++;
         if (expressions % 15 == 14) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule

FILE: add_sub_paren_expression_evaluator.f
hdl/ape_pkg.sv
hdl/ape_front.sv
hdl/ape_back.sv
hdl/ape_outq.sv
hdl/add_sub_paren_expression_evaluator.sv
hdl/ape_checker.sv
tb/evaluator_checker.sv
tb/testbench.sv
